@@ hw/rtl/kdc_pkg.sv @@
// Package for the k-means clustering unit: size defaults, field widths,
// register indexes and the sequencer state type. No dependencies.
package kdc_pkg;

   // Default sizes of the stores
   localparam int MaxDocuments = 64;
   localparam int MaxFeatures  = 16;
   localparam int MaxClusters  = 16;

   // Fixed field widths
   localparam int ScoreWidth   = 32;
   localparam int DocOutWidth  = 6;
   localparam int ClusOutWidth = 4;
   localparam int DistWidth    = 64;

   // Configuration register indexes (paddr[3:2])
   localparam logic [1:0] RegNumClusters  = 2'd0;
   localparam logic [1:0] RegNumDocuments = 2'd1;
   localparam logic [1:0] RegNumFeatures  = 2'd2;
   localparam logic [1:0] RegMaxIter      = 2'd3;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_INIT,
      ST_CLEAR,
      ST_ACC_RD_ASSIGN,
      ST_ACC_GET_ASSIGN,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_DIV_CHECK,
      ST_DIV_RD,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_WR,
      ST_NN_RD_ASSIGN,
      ST_NN_GET_ASSIGN,
      ST_NN_CLUSTER,
      ST_NN_RD,
      ST_NN_DIFF,
      ST_NN_MUL,
      ST_NN_ADD,
      ST_NN_CMP,
      ST_NN_WR,
      ST_PASS_END,
      ST_OUT_RD,
      ST_OUT_GET,
      ST_OUT_SEND
   } kdc_state_type;

endpackage

@@ hw/rtl/kdc_if.sv @@
// Valid/ready channel interfaces for score words in and cluster words out.
// Depends on kdc_pkg for field widths.
interface kdc_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [kdc_pkg::ScoreWidth-1:0] score_value;
   logic                               last_score;
   modport source (output valid, score_value, last_score, input ready);
   modport sink   (input valid, score_value, last_score, output ready);
endinterface

interface kdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [kdc_pkg::DocOutWidth-1:0]   document_index;
   logic [kdc_pkg::ClusOutWidth-1:0]  cluster_index;
   logic                              converged;
   logic                              last_result;
   modport source (output valid, document_index, cluster_index, converged, last_result,
                   input ready);
   modport sink   (input valid, document_index, cluster_index, converged, last_result,
                   output ready);
endinterface

@@ hw/rtl/kmeans_document_clustering_unit.sv @@
// Lloyd k-means clustering unit: score store, sequencer and one shared
// arithmetic path (adder, restoring divider, multiplier). Uses kdc_pkg, kdc_if.
//
// Usage: score words enter on req_ch (valid/ready), document-major, one per
// cycle while loading, and are kept in the score store. The word marked
// last_score starts clustering; req_ch.ready stays low until every result
// word has left. Each pass clears the sums, accumulates them, forms the
// centroids with the one-bit-per-cycle divider and reassigns each document
// to its nearest centroid. Passes repeat until nothing moves or
// max_iterations is reached. Then rsp_ch gives one word per document, the
// next only after the last was taken; a stalled receiver simply holds the
// word in the output register. Configuration goes through the APB-style
// port and must be written by the user only while idle; the block itself
// does not enforce this. Synchronous reset returns to loading with the
// registers at their defaults; stored scores are not cleared.
module kmeans_document_clustering_unit #(
   parameter int MAX_DOCUMENTS = kdc_pkg::MaxDocuments,
   parameter int MAX_FEATURES  = kdc_pkg::MaxFeatures,
   parameter int MAX_CLUSTERS  = kdc_pkg::MaxClusters
) (
   input  logic        clock,
   input  logic        reset,
   kdc_req_if.sink     req_ch,
   kdc_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int Depth = MAX_DOCUMENTS * MAX_FEATURES;
   localparam int SumDepth = MAX_CLUSTERS * MAX_FEATURES;
   localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LPW  = $clog2(Depth + 1);
   localparam int SAW  = (SumDepth > 1) ? $clog2(SumDepth) : 1;
   localparam int DIW  = (MAX_DOCUMENTS > 1) ? $clog2(MAX_DOCUMENTS) : 1;
   localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CIW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int DCW  = $clog2(MAX_DOCUMENTS + 1);
   localparam int FCW  = $clog2(MAX_FEATURES + 1);
   localparam int CCW  = $clog2(MAX_CLUSTERS + 1);
   localparam int SW   = kdc_pkg::ScoreWidth;
   localparam int SUMW = SW + DIW;
   localparam int DVW  = $clog2(SUMW + 1);
   localparam int DW   = kdc_pkg::DistWidth;

   // Configuration registers
   logic [4:0] nc_ff, nf_ff;
   logic [6:0] nd_ff;
   logic [7:0] max_iter_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff       <= 5'd2;
         nd_ff       <= 7'd64;
         nf_ff       <= 5'd16;
         max_iter_ff <= 8'd64;
      end else if (csr_write) begin
         case (paddr[3:2])
            kdc_pkg::RegNumClusters:  nc_ff       <= pwdata[4:0];
            kdc_pkg::RegNumDocuments: nd_ff       <= pwdata[6:0];
            kdc_pkg::RegNumFeatures:  nf_ff       <= pwdata[4:0];
            kdc_pkg::RegMaxIter:      max_iter_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         kdc_pkg::RegNumClusters:  prdata = {27'd0, nc_ff};
         kdc_pkg::RegNumDocuments: prdata = {25'd0, nd_ff};
         kdc_pkg::RegNumFeatures:  prdata = {27'd0, nf_ff};
         kdc_pkg::RegMaxIter:      prdata = {24'd0, max_iter_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   // Clamp the sizes into range
   logic [CCW-1:0] nc_eff;
   logic [DCW-1:0] nd_eff;
   logic [FCW-1:0] nf_eff;
   logic [7:0]     iter_limit;

   always_comb begin
      if (nc_ff == 5'd0) nc_eff = CCW'(1);
      else if (int'(nc_ff) > MAX_CLUSTERS) nc_eff = CCW'(MAX_CLUSTERS);
      else nc_eff = CCW'(nc_ff);
      if (nd_ff == 7'd0) nd_eff = DCW'(1);
      else if (int'(nd_ff) > MAX_DOCUMENTS) nd_eff = DCW'(MAX_DOCUMENTS);
      else nd_eff = DCW'(nd_ff);
      if (nf_ff == 5'd0) nf_eff = FCW'(1);
      else if (int'(nf_ff) > MAX_FEATURES) nf_eff = FCW'(MAX_FEATURES);
      else nf_eff = FCW'(nf_ff);
      iter_limit = (max_iter_ff == 8'd0) ? 8'd1 : max_iter_ff;
   end

   // Sequencer and datapath registers
   kdc_pkg::kdc_state_type state_ff, state_in;
   logic [LPW-1:0]  load_pos_ff;
   logic [DIW-1:0]  d_ff;
   logic [FW-1:0]   f_ff;
   logic [CIW-1:0]  c_ff;
   logic [CIW-1:0]  cmod_ff;
   logic [CIW-1:0]  cur_c_ff;
   logic [CIW-1:0]  best_c_ff;
   logic            found_ff;
   logic [AW-1:0]   base_ff;
   logic [SAW-1:0]  clr_ff;
   logic [DCW-1:0]  counts_ff [MAX_CLUSTERS];
   logic [7:0]      iter_ff;
   logic            changed_ff;
   logic            conv_ff;
   logic            div_neg_ff;
   logic [SUMW-1:0] div_q_ff;
   logic [DCW:0]    div_rem_ff;
   logic [DCW-1:0]  div_den_ff;
   logic [DVW-1:0]  div_step_ff;
   logic [SW-1:0]   mag_ff;
   logic [DW-1:0]   sq_ff;
   logic [DW-1:0]   dist_ff;
   logic [DW-1:0]   best_ff;

   // Output register
   logic                             rsp_valid_ff;
   logic [kdc_pkg::DocOutWidth-1:0]  rsp_doc_ff;
   logic [kdc_pkg::ClusOutWidth-1:0] rsp_clus_ff;
   logic                             rsp_conv_ff;
   logic                             rsp_last_ff;

   // Memories
   logic [SW-1:0]   score_mem [Depth];
   logic [CIW-1:0]  assign_mem [MAX_DOCUMENTS];
   logic [SUMW-1:0] sum_mem [SumDepth];
   logic [SW-1:0]   cent_mem [SumDepth];
   logic [SW-1:0]   score_rd_ff;
   logic [CIW-1:0]  assign_rd_ff;
   logic [SUMW-1:0] sum_rd_ff;
   logic [SW-1:0]   cent_rd_ff;

   logic            req_fire, rsp_fire;
   logic            d_last, f_last, c_last, cmod_last, store_room;
   logic [AW-1:0]   score_addr;
   logic [SAW-1:0]  cf_addr, sum_addr;
   logic            score_we, assign_we, sum_we, cent_we;
   logic [CIW-1:0]  assign_wd;
   logic [SUMW-1:0] sum_wd;
   logic [SUMW-1:0] div_mag;
   logic [DCW:0]    div_shift;
   logic [SUMW-1:0] div_signed_q;
   logic [SW:0]     diff;
   logic [DW:0]     dist_sum;

   assign req_ch.ready = (state_ff == kdc_pkg::ST_LOAD);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign rsp_fire     = rsp_valid_ff & rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.document_index = rsp_doc_ff;
   assign rsp_ch.cluster_index  = rsp_clus_ff;
   assign rsp_ch.converged      = rsp_conv_ff;
   assign rsp_ch.last_result    = rsp_last_ff;

   assign d_last     = (DCW'(d_ff) + DCW'(1)) == nd_eff;
   assign f_last     = (FCW'(f_ff) + FCW'(1)) == nf_eff;
   assign c_last     = (CCW'(c_ff) + CCW'(1)) == nc_eff;
   assign cmod_last  = (CCW'(cmod_ff) + CCW'(1)) == nc_eff;
   assign store_room = load_pos_ff < LPW'(Depth);

   // Address generation
   assign score_addr = (state_ff == kdc_pkg::ST_LOAD) ? load_pos_ff[AW-1:0]
                                                      : base_ff + AW'(f_ff);
   assign cf_addr    = SAW'(SAW'(c_ff) * SAW'(MAX_FEATURES) + SAW'(f_ff));
   assign sum_addr   = (state_ff == kdc_pkg::ST_CLEAR) ? clr_ff : cf_addr;

   // Shared arithmetic
   assign div_mag      = sum_rd_ff[SUMW-1] ? (~sum_rd_ff + SUMW'(1)) : sum_rd_ff;
   assign div_shift    = {div_rem_ff[DCW-1:0], div_q_ff[SUMW-1]};
   assign div_signed_q = div_neg_ff ? (~div_q_ff + SUMW'(1)) : div_q_ff;
   assign diff         = {score_rd_ff[SW-1], score_rd_ff} - {cent_rd_ff[SW-1], cent_rd_ff};
   assign dist_sum     = {1'b0, dist_ff} + {1'b0, sq_ff};

   // Memory write controls
   assign score_we  = req_fire & store_room;
   assign assign_we = (state_ff == kdc_pkg::ST_INIT) ||
                      ((state_ff == kdc_pkg::ST_NN_WR) && (best_c_ff != cur_c_ff));
   assign assign_wd = (state_ff == kdc_pkg::ST_INIT) ? cmod_ff : best_c_ff;
   assign sum_we    = (state_ff == kdc_pkg::ST_CLEAR) || (state_ff == kdc_pkg::ST_ACC_WR);
   assign sum_wd    = (state_ff == kdc_pkg::ST_CLEAR) ? SUMW'(0)
                      : sum_rd_ff + SUMW'(signed'(score_rd_ff));
   assign cent_we   = (state_ff == kdc_pkg::ST_DIV_WR);

   always_ff @(posedge clock) begin
      if (score_we) score_mem[score_addr] <= req_ch.score_value;
      score_rd_ff <= score_mem[score_addr];
   end

   always_ff @(posedge clock) begin
      if (assign_we) assign_mem[d_ff] <= assign_wd;
      assign_rd_ff <= assign_mem[d_ff];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_addr] <= sum_wd;
      sum_rd_ff <= sum_mem[sum_addr];
   end

   always_ff @(posedge clock) begin
      if (cent_we) cent_mem[cf_addr] <= div_signed_q[SW-1:0];
      cent_rd_ff <= cent_mem[cf_addr];
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= kdc_pkg::ST_LOAD;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdc_pkg::ST_LOAD:
            if (req_fire && req_ch.last_score) state_in = kdc_pkg::ST_INIT;
         kdc_pkg::ST_INIT:
            if (d_last) state_in = kdc_pkg::ST_CLEAR;
         kdc_pkg::ST_CLEAR:
            if (clr_ff == SAW'(SumDepth - 1)) state_in = kdc_pkg::ST_ACC_RD_ASSIGN;
         kdc_pkg::ST_ACC_RD_ASSIGN:  state_in = kdc_pkg::ST_ACC_GET_ASSIGN;
         kdc_pkg::ST_ACC_GET_ASSIGN: state_in = kdc_pkg::ST_ACC_RD;
         kdc_pkg::ST_ACC_RD:         state_in = kdc_pkg::ST_ACC_WR;
         kdc_pkg::ST_ACC_WR: begin
            if (!f_last)      state_in = kdc_pkg::ST_ACC_RD;
            else if (!d_last) state_in = kdc_pkg::ST_ACC_RD_ASSIGN;
            else              state_in = kdc_pkg::ST_DIV_CHECK;
         end
         kdc_pkg::ST_DIV_CHECK: begin
            if (counts_ff[c_ff] != DCW'(0)) state_in = kdc_pkg::ST_DIV_RD;
            else if (c_last)                state_in = kdc_pkg::ST_NN_RD_ASSIGN;
         end
         kdc_pkg::ST_DIV_RD:   state_in = kdc_pkg::ST_DIV_LOAD;
         kdc_pkg::ST_DIV_LOAD: state_in = kdc_pkg::ST_DIV_RUN;
         kdc_pkg::ST_DIV_RUN:
            if (div_step_ff == DVW'(SUMW - 1)) state_in = kdc_pkg::ST_DIV_WR;
         kdc_pkg::ST_DIV_WR: begin
            if (!f_last)     state_in = kdc_pkg::ST_DIV_RD;
            else if (c_last) state_in = kdc_pkg::ST_NN_RD_ASSIGN;
            else             state_in = kdc_pkg::ST_DIV_CHECK;
         end
         kdc_pkg::ST_NN_RD_ASSIGN:  state_in = kdc_pkg::ST_NN_GET_ASSIGN;
         kdc_pkg::ST_NN_GET_ASSIGN: state_in = kdc_pkg::ST_NN_CLUSTER;
         kdc_pkg::ST_NN_CLUSTER: begin
            if (counts_ff[c_ff] != DCW'(0)) state_in = kdc_pkg::ST_NN_RD;
            else if (c_last)                state_in = kdc_pkg::ST_NN_WR;
         end
         kdc_pkg::ST_NN_RD:   state_in = kdc_pkg::ST_NN_DIFF;
         kdc_pkg::ST_NN_DIFF: state_in = kdc_pkg::ST_NN_MUL;
         kdc_pkg::ST_NN_MUL:  state_in = kdc_pkg::ST_NN_ADD;
         kdc_pkg::ST_NN_ADD:
            state_in = f_last ? kdc_pkg::ST_NN_CMP : kdc_pkg::ST_NN_RD;
         kdc_pkg::ST_NN_CMP:
            state_in = c_last ? kdc_pkg::ST_NN_WR : kdc_pkg::ST_NN_CLUSTER;
         kdc_pkg::ST_NN_WR:
            state_in = d_last ? kdc_pkg::ST_PASS_END : kdc_pkg::ST_NN_RD_ASSIGN;
         kdc_pkg::ST_PASS_END: begin
            if (!changed_ff || ({1'b0, iter_ff} + 9'd1 >= {1'b0, iter_limit}))
               state_in = kdc_pkg::ST_OUT_RD;
            else
               state_in = kdc_pkg::ST_CLEAR;
         end
         kdc_pkg::ST_OUT_RD:  state_in = kdc_pkg::ST_OUT_GET;
         kdc_pkg::ST_OUT_GET: state_in = kdc_pkg::ST_OUT_SEND;
         kdc_pkg::ST_OUT_SEND:
            if (rsp_fire) state_in = d_last ? kdc_pkg::ST_LOAD : kdc_pkg::ST_OUT_RD;
         default: state_in = kdc_pkg::ST_LOAD;
      endcase
   end

   // Control counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff  <= '0;
         d_ff         <= '0;
         f_ff         <= '0;
         c_ff         <= '0;
         cmod_ff      <= '0;
         base_ff      <= '0;
         clr_ff       <= '0;
         iter_ff      <= '0;
         changed_ff   <= 1'b0;
         conv_ff      <= 1'b0;
         found_ff     <= 1'b0;
         div_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CLUSTERS; i++) counts_ff[i] <= '0;
      end else begin
         case (state_ff)
            kdc_pkg::ST_LOAD: begin
               if (req_fire && store_room) load_pos_ff <= load_pos_ff + LPW'(1);
               d_ff    <= '0;
               cmod_ff <= '0;
               iter_ff <= '0;
            end
            kdc_pkg::ST_INIT: begin
               cmod_ff <= cmod_last ? '0 : cmod_ff + CIW'(1);
               d_ff    <= d_ff + DIW'(1);
               clr_ff  <= '0;
            end
            kdc_pkg::ST_CLEAR: begin
               // Wipe sums and counts for this pass
               clr_ff     <= clr_ff + SAW'(1);
               changed_ff <= 1'b0;
               d_ff       <= '0;
               base_ff    <= '0;
               for (int i = 0; i < MAX_CLUSTERS; i++) counts_ff[i] <= '0;
            end
            kdc_pkg::ST_ACC_GET_ASSIGN: begin
               c_ff <= assign_rd_ff;
               f_ff <= '0;
               counts_ff[assign_rd_ff] <= counts_ff[assign_rd_ff] + DCW'(1);
            end
            kdc_pkg::ST_ACC_WR: begin
               if (!f_last) begin
                  f_ff <= f_ff + FW'(1);
               end else begin
                  d_ff    <= d_ff + DIW'(1);
                  base_ff <= base_ff + AW'(nf_eff);
                  c_ff    <= '0;
                  f_ff    <= '0;
               end
            end
            kdc_pkg::ST_DIV_CHECK: begin
               f_ff <= '0;
               if (counts_ff[c_ff] == DCW'(0)) begin
                  c_ff <= c_last ? '0 : c_ff + CIW'(1);
                  d_ff <= '0;
                  base_ff <= '0;
               end
            end
            kdc_pkg::ST_DIV_LOAD: begin
               div_step_ff <= '0;
            end
            kdc_pkg::ST_DIV_RUN: begin
               div_step_ff <= div_step_ff + DVW'(1);
            end
            kdc_pkg::ST_DIV_WR: begin
               if (!f_last) begin
                  f_ff <= f_ff + FW'(1);
               end else begin
                  c_ff    <= c_last ? '0 : c_ff + CIW'(1);
                  f_ff    <= '0;
                  d_ff    <= '0;
                  base_ff <= '0;
               end
            end
            kdc_pkg::ST_NN_GET_ASSIGN: begin
               c_ff     <= '0;
               found_ff <= 1'b0;
            end
            kdc_pkg::ST_NN_CLUSTER: begin
               f_ff <= '0;
               if (counts_ff[c_ff] == DCW'(0) && !c_last) c_ff <= c_ff + CIW'(1);
            end
            kdc_pkg::ST_NN_ADD: begin
               if (!f_last) f_ff <= f_ff + FW'(1);
            end
            kdc_pkg::ST_NN_CMP: begin
               found_ff <= 1'b1;
               if (!c_last) c_ff <= c_ff + CIW'(1);
            end
            kdc_pkg::ST_NN_WR: begin
               if (best_c_ff != cur_c_ff) changed_ff <= 1'b1;
               d_ff    <= d_ff + DIW'(1);
               base_ff <= base_ff + AW'(nf_eff);
            end
            kdc_pkg::ST_PASS_END: begin
               iter_ff <= iter_ff + 8'd1;
               conv_ff <= !changed_ff;
               clr_ff  <= '0;
               d_ff    <= '0;
            end
            kdc_pkg::ST_OUT_GET: begin
               rsp_valid_ff <= 1'b1;
            end
            kdc_pkg::ST_OUT_SEND: begin
               // Hold the word until taken
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  d_ff         <= d_last ? '0 : d_ff + DIW'(1);
                  if (d_last) load_pos_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers of the shared arithmetic and the output word
   always_ff @(posedge clock) begin
      case (state_ff)
         kdc_pkg::ST_DIV_LOAD: begin
            div_neg_ff <= sum_rd_ff[SUMW-1];
            div_q_ff   <= div_mag;
            div_rem_ff <= '0;
            div_den_ff <= counts_ff[c_ff];
         end
         kdc_pkg::ST_DIV_RUN: begin
            // One quotient bit per cycle
            if (div_shift >= {1'b0, div_den_ff}) begin
               div_rem_ff <= div_shift - {1'b0, div_den_ff};
               div_q_ff   <= {div_q_ff[SUMW-2:0], 1'b1};
            end else begin
               div_rem_ff <= div_shift;
               div_q_ff   <= {div_q_ff[SUMW-2:0], 1'b0};
            end
         end
         kdc_pkg::ST_NN_GET_ASSIGN: begin
            cur_c_ff  <= assign_rd_ff;
            best_c_ff <= assign_rd_ff;
         end
         kdc_pkg::ST_NN_CLUSTER: begin
            dist_ff <= '0;
         end
         kdc_pkg::ST_NN_DIFF: begin
            mag_ff <= diff[SW] ? SW'(~diff + (SW + 1)'(1)) : diff[SW-1:0];
         end
         kdc_pkg::ST_NN_MUL: begin
            sq_ff <= DW'(mag_ff) * DW'(mag_ff);
         end
         kdc_pkg::ST_NN_ADD: begin
            // Saturate at all ones
            dist_ff <= dist_sum[DW] ? '1 : dist_sum[DW-1:0];
         end
         kdc_pkg::ST_NN_CMP: begin
            if (!found_ff || dist_ff < best_ff) begin
               best_ff   <= dist_ff;
               best_c_ff <= c_ff;
            end
         end
         kdc_pkg::ST_OUT_GET: begin
            rsp_doc_ff  <= kdc_pkg::DocOutWidth'(d_ff);
            rsp_clus_ff <= kdc_pkg::ClusOutWidth'(assign_rd_ff);
            rsp_conv_ff <= conv_ff;
            rsp_last_ff <= d_last;
         end
         default: ;
      endcase
   end

endmodule

@@ verif/tb_kmeans_document_clustering_unit.sv @@
// Self-checking bench for the k-means clustering unit: score words in, cluster words out.
// Holds its own Lloyd clustering predictor. Depends on kdc_pkg, kdc_if and the top-level RTL.
module tb_kmeans_document_clustering_unit;

   localparam int StoreDepth = kdc_pkg::MaxDocuments * kdc_pkg::MaxFeatures;
   localparam int CycleLimit = 4000000;

   typedef struct {
      logic [31:0] value;
      logic        last;
   } score_word_type;

   typedef struct {
      logic [5:0] document;
      logic [3:0] cluster;
      logic       converged;
      logic       last;
   } cluster_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   kdc_req_if req_ch ();
   kdc_rsp_if rsp_ch ();

   kmeans_document_clustering_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch.sink),
      .rsp_ch  (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Free-running clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: stored scores, load pointer and register copies
   logic [31:0]   score_mem [StoreDepth];
   bit            score_seen [StoreDepth];
   int unsigned   load_pos = 0;
   logic [4:0]    cfg_clusters = 5'd2;
   logic [6:0]    cfg_documents = 7'd64;
   logic [4:0]    cfg_features = 5'd16;
   logic [7:0]    cfg_iter_limit = 8'd64;

   score_word_type   pending_scores[$];
   cluster_word_type expected_assignments[$];
   int            failures = 0;
   int            cycles = 0;
   bit            gaps_on = 1'b0;
   bit            req_taken = 1'b0;
   int            req_hold = 0;
   int            rsp_hold = 0;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint score_at(int unsigned a);
      if (a >= StoreDepth || !score_seen[a]) return 0;
      return longint'($signed(score_mem[a]));
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on || $urandom_range(0, 1) == 0) return 0;
      r = $urandom_range(0, 9);
      return (r < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // Store one score; on the last one run Lloyd passes and queue one word per document
   task automatic take_score(logic [31:0] value, logic last);
      int unsigned      nc, nd, nf, limit, iter, best_c;
      int unsigned      member [kdc_pkg::MaxDocuments];
      longint           sums [kdc_pkg::MaxClusters][kdc_pkg::MaxFeatures];
      int unsigned      counts [kdc_pkg::MaxClusters];
      longint           cent [kdc_pkg::MaxClusters][kdc_pkg::MaxFeatures];
      longint           diff;
      longint unsigned  mag, sq, dist_acc, best;
      bit               moved, stable, found;
      cluster_word_type w;
      if (load_pos < StoreDepth) begin
         score_mem[load_pos] = value;
         score_seen[load_pos] = 1'b1;
         load_pos++;
      end
      if (!last) return;
      nc = clamp_to(cfg_clusters, kdc_pkg::MaxClusters);
      nd = clamp_to(cfg_documents, kdc_pkg::MaxDocuments);
      nf = clamp_to(cfg_features, kdc_pkg::MaxFeatures);
      limit = (cfg_iter_limit == 0) ? 1 : cfg_iter_limit;
      for (int d = 0; d < nd; d++) member[d] = d % nc;
      iter = 0;
      stable = 1'b0;
      forever begin
         for (int c = 0; c < kdc_pkg::MaxClusters; c++) begin
            counts[c] = 0;
            for (int f = 0; f < kdc_pkg::MaxFeatures; f++) sums[c][f] = 0;
         end
         for (int d = 0; d < nd; d++) begin
            for (int f = 0; f < nf; f++) sums[member[d]][f] += score_at(d * nf + f);
            counts[member[d]]++;
         end
         // Empty clusters keep no centroid and are skipped below
         for (int c = 0; c < nc; c++)
            if (counts[c] != 0)
               for (int f = 0; f < nf; f++) cent[c][f] = sums[c][f] / longint'(counts[c]);
         moved = 1'b0;
         for (int d = 0; d < nd; d++) begin
            found = 1'b0;
            best = 0;
            best_c = member[d];
            for (int c = 0; c < nc; c++) begin
               if (counts[c] == 0) continue;
               dist_acc = 0;
               for (int f = 0; f < nf; f++) begin
                  diff = score_at(d * nf + f) - cent[c][f];
                  mag = (diff < 0) ? longint'(-diff) : longint'(diff);
                  sq = mag * mag;
                  dist_acc = (dist_acc > ~64'd0 - sq) ? ~64'd0 : dist_acc + sq;
               end
               // Strict compare keeps the lowest cluster on a tie
               if (!found || dist_acc < best) begin
                  found = 1'b1;
                  best = dist_acc;
                  best_c = c;
               end
            end
            if (best_c != member[d]) begin
               member[d] = best_c;
               moved = 1'b1;
            end
         end
         iter++;
         if (!moved) begin
            stable = 1'b1;
            break;
         end
         if (iter >= limit) break;
      end
      for (int d = 0; d < nd; d++) begin
         w.document = d[5:0];
         w.cluster = member[d][3:0];
         w.converged = stable;
         w.last = (d + 1 == nd);
         expected_assignments.push_back(w);
      end
      load_pos = 0;
   endtask

   // Cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Score side: note accepted words and feed the predictor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         take_score(req_ch.score_value, req_ch.last_score);
         req_taken = 1'b1;
      end
   end

   // Score driver: advance on acceptance, insert random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid = 1'b0;
         req_ch.score_value = '0;
         req_ch.last_score = 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         req_taken = 1'b0;
         if (req_hold > 0) begin
            req_ch.valid = 1'b0;
            req_hold--;
         end else if (pending_scores.size() > 0) begin
            score_word_type s;
            s = pending_scores.pop_front();
            req_ch.score_value = s.value;
            req_ch.last_score = s.last;
            req_ch.valid = 1'b1;
            req_hold = pick_gap();
         end else begin
            req_ch.valid = 1'b0;
         end
      end
   end

   // Result receiver: random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready = 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (rsp_ch.valid) rsp_hold = pick_gap();
      end
   end

   // Result checker: compare each word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_assignments.size() == 0) begin
            $display("%0t: unexpected word doc=%0d cluster=%0d", $time,
                     rsp_ch.document_index, rsp_ch.cluster_index);
            failures++;
         end else begin
            cluster_word_type e;
            e = expected_assignments.pop_front();
            if (rsp_ch.document_index !== e.document || rsp_ch.cluster_index !== e.cluster ||
                rsp_ch.converged !== e.converged || rsp_ch.last_result !== e.last) begin
               $display("%0t: mismatch expected doc=%0d cl=%0d conv=%0d last=%0d", $time,
                        e.document, e.cluster, e.converged, e.last);
               $display("%0t:          actual   doc=%0d cl=%0d conv=%0d last=%0d", $time,
                        rsp_ch.document_index, rsp_ch.cluster_index, rsp_ch.converged,
                        rsp_ch.last_result);
               failures++;
            end
         end
      end
   end

   function automatic logic [31:0] reg_mask(logic [1:0] idx);
      case (idx)
         kdc_pkg::RegNumClusters:  return 32'h1F;
         kdc_pkg::RegNumDocuments: return 32'h7F;
         kdc_pkg::RegNumFeatures:  return 32'h1F;
         default:                  return 32'hFF;
      endcase
   endfunction

   task automatic csr_read_check(logic [1:0] idx, logic [31:0] want);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b0;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if ((prdata & reg_mask(idx)) !== (want & reg_mask(idx))) begin
         $display("%0t: register %0d expected %0h actual %0h", $time, idx,
                  want & reg_mask(idx), prdata);
         failures++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      case (idx)
         kdc_pkg::RegNumClusters:  cfg_clusters = value[4:0];
         kdc_pkg::RegNumDocuments: cfg_documents = value[6:0];
         kdc_pkg::RegNumFeatures:  cfg_features = value[4:0];
         default:                  cfg_iter_limit = value[7:0];
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      csr_read_check(idx, value);
   endtask

   // Hold until every word is in and every result out, then let the block settle
   task automatic wait_idle();
      while (pending_scores.size() > 0 || req_ch.valid || expected_assignments.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(int nc, int nd, int nf, int iters);
      wait_idle();
      csr_write(kdc_pkg::RegNumClusters, nc);
      csr_write(kdc_pkg::RegNumDocuments, nd);
      csr_write(kdc_pkg::RegNumFeatures, nf);
      csr_write(kdc_pkg::RegMaxIter, iters);
      gaps_on = $urandom_range(0, 3) != 0;
   endtask

   // Queue one data set of the given scores, last flag on the final word
   task automatic queue_scores(logic [31:0] vals[$]);
      score_word_type s;
      foreach (vals[i]) begin
         s.value = vals[i];
         s.last = (i == vals.size() - 1);
         pending_scores.push_back(s);
      end
   endtask

   task automatic queue_random_set(int extra);
      logic [31:0] vals[$];
      logic [31:0] centers[4];
      int          n;
      n = clamp_to(cfg_documents, kdc_pkg::MaxDocuments) *
          clamp_to(cfg_features, kdc_pkg::MaxFeatures);
      n = (n + extra > StoreDepth) ? StoreDepth : n + extra;
      foreach (centers[k]) centers[k] = $urandom() >> $urandom_range(0, 16);
      for (int i = 0; i < n; i++)
         if ($urandom_range(0, 3) == 0) vals.push_back($urandom());
         else vals.push_back(centers[$urandom_range(0, 3)] + $urandom_range(0, 2000) - 1000);
      queue_scores(vals);
   endtask

   int random_words = 0;

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Defaults after reset
      csr_read_check(kdc_pkg::RegNumClusters, 2);
      csr_read_check(kdc_pkg::RegNumDocuments, 64);
      csr_read_check(kdc_pkg::RegNumFeatures, 16);
      csr_read_check(kdc_pkg::RegMaxIter, 64);

      // Score extremes, every bit toggled
      configure(3, 4, 2, 16);
      queue_scores('{32'h80000000, 32'h7FFFFFFF, 32'h80000001, 32'h7FFFFFFE,
                     32'h00000000, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA});
      // More clusters than documents leaves empty clusters
      configure(5, 3, 2, 8);
      queue_scores('{32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h00000005,
                     32'h00010001, 32'h00020000});
      // Zero registers act as one
      configure(0, 0, 0, 0);
      queue_scores('{32'h12345678});
      // Iteration limit of one on a set that the first pass already leaves in place
      configure(2, 4, 1, 1);
      queue_scores('{32'd0, 32'd100, 32'd1, 32'd101});
      // Equal distances go to the lowest cluster
      configure(2, 2, 1, 4);
      queue_scores('{32'd5, 32'd5});
      // Oversized cluster and feature counts clamp
      configure(31, 1, 31, 2);
      queue_random_set(0);
      // Oversized document count clamps
      configure(2, 127, 1, 2);
      queue_random_set(0);

      // Random sets, mostly small
      while (random_words < 20) begin
         int nc_w, nd_w, nf_w, it_w, extra;
         nc_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
         nd_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
         nf_w = $urandom_range(0, 4);
         case ($urandom_range(0, 4))
            0: it_w = 0;
            1: it_w = 1;
            2: it_w = 255;
            default: it_w = $urandom_range(2, 20);
         endcase
         extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
         configure(nc_w, nd_w, nf_w, it_w);
         queue_random_set(extra);
         random_words += clamp_to(nd_w, kdc_pkg::MaxDocuments) *
                         clamp_to(nf_w, kdc_pkg::MaxFeatures) + extra;
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
